// ===== design/button_double_tap_hold_detector_core_macros.svh =====
// Assertion macros for the button tap/hold detector.
// Needs clk and arst_n in the scope of each use; empty when SYNTHESIS is set.
`ifndef BUTTON_DOUBLE_TAP_HOLD_DETECTOR_CORE_MACROS_SVH
`define BUTTON_DOUBLE_TAP_HOLD_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BDTH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdth: same-cycle check failed");
`define BDTH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bdth: next-cycle check failed");
`else
`define BDTH_ASSERT_IMP(lbl, ante, cons)
`define BDTH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/bdth_pkg.sv =====
// Shared types and constants for the button tap/hold detector.
// No dependencies.
package bdth_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DTAP_WINDOW = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 8'd2;

	localparam logic [15:0] SHORT_PRESS_RST = 16'd400;
	localparam logic [15:0] DTAP_WINDOW_RST = 16'd600;
	localparam logic [15:0] HOLD_RST = 16'd10000;

	// ceil(2^26 / 1000): exact quotient for all 16-bit dividends
	localparam logic [16:0] SEC_RECIP = 17'd67109;
	localparam int SEC_SHIFT = 26;

	typedef struct packed {
		logic [15:0] short_tap_ms;
		logic [15:0] tap_window_ms;
		logic [15:0] hold_ms;
	} cfg_t;

	// first member lands in the top bits, so double_tap_seen is bit 0
	typedef struct packed {
		logic [6:0] seconds_left;
		logic ap_mode_hold;
		logic holding;
		logic factory_reset;
		logic start_ap;
		logic double_tap_seen;
	} res_t;

endpackage

// ===== design/button_double_tap_hold_detector_core.sv =====
// Stages: input register, decision logic, result register.
// Throughput: one poll per cycle unless m_tready stalls the result register.
// While a result waits on m_tready the input register takes one more poll, then stalls.
// Reset (arst_n low, asynchronous) clears press and tap state, empties both
// registers and returns the configuration to 400 / 600 / 10000 ms.
// Depends on bdth_pkg, bdth_cfg_regs and bdth_tracker.
module button_double_tap_hold_detector_core
	import bdth_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,  // button_down, now_ms[31:0], pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // double_tap_seen, start_ap, factory_reset,
	                                        // holding, ap_mode_hold, seconds_left[6:0], pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg;
	res_t        res;
	res_t        res_q;
	logic        out_valid_q;
	logic        valid_s1;
	logic        button_s1;
	logic [31:0] now_s1;
	logic        advance;
	logic        in_xfer;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xfer = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0, res_q};

	bdth_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdth_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.button_down (button_s1),
		.now_ms      (now_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			button_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
		if (advance) begin
			res_q <= res;
		end
	end

endmodule

// ===== design/bdth_sec_div.sv =====
// Whole seconds from a 16-bit millisecond count, by reciprocal multiply.
// Depends on bdth_pkg.
module bdth_sec_div
	import bdth_pkg::*;
(
	input  logic [15:0] ms,
	output logic [6:0]  secs
);

	logic [32:0] prod;

	assign prod = {17'b0, ms} * {16'b0, SEC_RECIP};
	assign secs = prod[SEC_SHIFT+6:SEC_SHIFT];

endmodule

// ===== design/bdth_cfg_regs.sv =====
// Configuration registers: short tap limit, double-tap window, hold time.
// Depends on bdth_pkg.
module bdth_cfg_regs
	import bdth_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_tap_ms <= SHORT_PRESS_RST;
			cfg_q.tap_window_ms <= DTAP_WINDOW_RST;
			cfg_q.hold_ms <= HOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SHORT_PRESS: cfg_q.short_tap_ms <= cfg_data;
				REG_DTAP_WINDOW: cfg_q.tap_window_ms <= cfg_data;
				REG_HOLD:        cfg_q.hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/bdth_tracker.sv =====
// Press/tap state and the per-poll decision logic.
// Depends on bdth_pkg, bdth_sec_div and the assertion macro header.
`include "button_double_tap_hold_detector_core_macros.svh"
module bdth_tracker
	import bdth_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        button_down,
	input  logic [31:0] now_ms,
	input  cfg_t        cfg,
	output res_t        res
);

	logic        pressed_q;
	logic [31:0] press_start_q;
	logic        tap_q;
	logic [31:0] first_tap_q;
	logic        ap_hold_q;

	logic        pressed_d;
	logic [31:0] press_start_d;
	logic        tap_d;
	logic [31:0] first_tap_d;
	logic        ap_hold_d;

	logic [31:0] held;
	logic [31:0] tap_age;
	logic        tap_live;
	logic        press_edge;
	logic        hold_reached;
	logic        short_release;
	logic [15:0] remain_ms;
	logic [6:0]  secs;

	assign held = now_ms - press_start_q;
	assign tap_age = now_ms - first_tap_q;
	assign tap_live = tap_q && !(!tap_age[31] && (tap_age > {16'b0, cfg.tap_window_ms}));
	assign press_edge = button_down && !pressed_q;
	assign hold_reached = held >= {16'b0, cfg.hold_ms};
	assign short_release = held < {16'b0, cfg.short_tap_ms};
	assign remain_ms = press_edge ? cfg.hold_ms : (cfg.hold_ms - held[15:0]);

	bdth_sec_div u_sec_div (
		.ms   (remain_ms),
		.secs (secs)
	);

	always_comb begin
		pressed_d = pressed_q;
		press_start_d = press_start_q;
		tap_d = tap_live;
		first_tap_d = first_tap_q;
		ap_hold_d = ap_hold_q;
		res = '0;
		if (press_edge) begin
			pressed_d = 1'b1;
			press_start_d = now_ms;
			ap_hold_d = tap_live;
			res.double_tap_seen = tap_live;
		end else if (button_down && pressed_q) begin
			if (hold_reached) begin
				if (ap_hold_q) begin
					res.start_ap = 1'b1;
					ap_hold_d = 1'b0;
					pressed_d = 1'b0;
				end else begin
					res.factory_reset = 1'b1;
				end
				tap_d = 1'b0;
			end
		end else if (pressed_q) begin
			// release
			if (short_release && !tap_live) begin
				tap_d = 1'b1;
				first_tap_d = now_ms;
			end else begin
				tap_d = 1'b0;
				ap_hold_d = 1'b0;
			end
			pressed_d = 1'b0;
		end
		res.holding = pressed_d;
		res.ap_mode_hold = pressed_d && ap_hold_d;
		res.seconds_left = (pressed_d && (press_edge || !hold_reached)) ? secs : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			press_start_q <= '0;
			tap_q <= 1'b0;
			first_tap_q <= '0;
			ap_hold_q <= 1'b0;
		end else if (step) begin
			pressed_q <= pressed_d;
			press_start_q <= press_start_d;
			tap_q <= tap_d;
			first_tap_q <= first_tap_d;
			ap_hold_q <= ap_hold_d;
		end
	end

	`BDTH_ASSERT_IMP(a_one_event, step, $onehot0({res.double_tap_seen, res.start_ap, res.factory_reset}))
	`BDTH_ASSERT_NXT(a_ap_ends_press, step && res.start_ap, !pressed_q && !ap_hold_q)
	`BDTH_ASSERT_NXT(a_dtap_arms, step && res.double_tap_seen, pressed_q && ap_hold_q)

endmodule
